### design/rvb_pkg.sv
// ----------------------------------------------------------------------------
// rvb_pkg
// Shared types, constants and helpers of the stereo comb/allpass reverb core.
// ----------------------------------------------------------------------------
package rvb_pkg;

	// network shape
	localparam int unsigned NUM_LINES    = 24;
	localparam int unsigned NUM_COMBS    = 16;
	localparam int unsigned REF_RATE     = 44100;
	localparam int unsigned RIGHT_SPREAD = 23;
	localparam int unsigned TOTAL_BASE   = 25450;
	localparam int unsigned STORE_PAD    = 32;

	localparam int unsigned COMB_BASE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int unsigned AP_BASE   [4] = '{556, 441, 341, 225};

	// fixed-point coefficients
	localparam int unsigned FB_OFFSET  = 45875;  // 0.70 in Q0.16
	localparam int unsigned FB_SPAN    = 18350;  // 0.28 in Q0.16
	localparam int unsigned DAMP_SCALE = 26214;  // 0.40 in Q0.16
	localparam int unsigned FEED_GAIN  = 7864;   // 8 * 983, input gain 0.015
	localparam int unsigned UNITY      = 65536;
	localparam int unsigned HALF       = 32768;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ROOM_SIZE    = 3'd0,
		REG_DAMPING      = 3'd1,
		REG_WET_LEVEL    = 3'd2,
		REG_DRY_LEVEL    = 3'd3,
		REG_STEREO_WIDTH = 3'd4,
		REG_STEREO_MODE  = 3'd5
	} reg_idx_t;

	typedef logic signed [15:0] sample_t;
	typedef logic signed [23:0] acc_t;
	typedef int unsigned line_tab_t [NUM_LINES];

	// base length of a line before rate scaling
	function automatic int unsigned line_base(input int unsigned i);
		if (i < 8)       return COMB_BASE[i];
		else if (i < 16) return COMB_BASE[i - 8] + RIGHT_SPREAD;
		else if (i < 20) return AP_BASE[i - 16];
		else             return AP_BASE[(i - 20) % 4] + RIGHT_SPREAD;
	endfunction

	// saturate to 24 bits
	function automatic acc_t sat24(input logic signed [47:0] x);
		if (x > 48'sd8388607)       return 24'sh7fffff;
		else if (x < -48'sd8388608) return 24'sh800000;
		else                        return x[23:0];
	endfunction

	// saturate to 16 bits
	function automatic sample_t sat16(input logic signed [47:0] x);
		if (x > 48'sd32767)       return 16'sh7fff;
		else if (x < -48'sd32768) return 16'sh8000;
		else                      return x[15:0];
	endfunction

endpackage

### design/rvb_if.sv
// ----------------------------------------------------------------------------
// rvb_if
// Valid/ready channels of the reverb core: sample pair in, sample pair out
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface rvb_in_if;
	logic             valid;
	logic             ready;
	rvb_pkg::sample_t left_in;
	rvb_pkg::sample_t right_in;
	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface rvb_out_if;
	logic             valid;
	logic             ready;
	rvb_pkg::sample_t left_out;
	rvb_pkg::sample_t right_out;
	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface rvb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  idx;
	logic [15:0] data;
	modport source (output valid, output idx, output data, input ready);
	modport sink   (input valid, input idx, input data, output ready);
endinterface

### design/stereo_comb_allpass_reverb_core.sv
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb_core
// Freeverb-style stereo reverb: 16 damped feedback combs and 8 allpasses
// sharing one delay memory, with wet/dry/width mixing and 16-bit saturation.
// ----------------------------------------------------------------------------
// Usage: after reset the delay memory is cleared, one entry a cycle; it
// holds floor(25450*SAMPLE_RATE/44100)+32 entries (25482 at 44.1 kHz). No
// sample pair is taken until then, configuration writes are taken at all
// times. Per sample pair the 24 delay lines are visited one after
// another through the single port of the delay memory: comb lines in
// read, lowpass, feedback and write-back steps, allpass lines in read
// and write-back steps, plus set-up and the output mix on shared
// multipliers. The next pair is taken as soon as the result is loaded
// into the output register. Write configuration only while the core is idle.
module stereo_comb_allpass_reverb_core #(
	parameter int unsigned SAMPLE_RATE = 44100
) (
	input  logic       clk,
	input  logic       arst_n,
	rvb_in_if.sink     in_ch,
	rvb_out_if.source  out_ch,
	rvb_cfg_if.sink    cfg
);

	// line length and offset tables, worked out at elaboration
	function automatic rvb_pkg::line_tab_t calc_len();
		rvb_pkg::line_tab_t t;
		int unsigned l;
		for (int unsigned i = 0; i < rvb_pkg::NUM_LINES; i++) begin
			l = (rvb_pkg::line_base(i) * SAMPLE_RATE) / rvb_pkg::REF_RATE;
			t[i] = (l < 1) ? 1 : l;
		end
		return t;
	endfunction

	function automatic rvb_pkg::line_tab_t calc_off();
		rvb_pkg::line_tab_t t;
		rvb_pkg::line_tab_t ln;
		int unsigned acc;
		ln = calc_len();
		acc = 0;
		for (int unsigned i = 0; i < rvb_pkg::NUM_LINES; i++) begin
			t[i] = acc;
			acc = acc + ln[i];
		end
		return t;
	endfunction

	localparam rvb_pkg::line_tab_t LEN_TAB = calc_len();
	localparam rvb_pkg::line_tab_t OFF_TAB = calc_off();
	localparam int unsigned DEPTH = int'((64'(rvb_pkg::TOTAL_BASE) * 64'(SAMPLE_RATE))
		/ 64'(rvb_pkg::REF_RATE)) + rvb_pkg::STORE_PAD;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned MAX_LEN = LEN_TAB[15];
	localparam int unsigned PW = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_PRE, ST_RD, ST_CM1, ST_CM2, ST_CM3, ST_CW,
		ST_SUM, ST_AW, ST_MXL, ST_MXR, ST_MXF
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] room_q, damping_q, wet_q, dry_q, width_q;
	logic        mode_q;

	// per-item registers
	rvb_pkg::sample_t in_l_q, in_r_q;
	logic [30:0] room_p_q, damp_p_q;
	logic [32:0] w1_p_q, w2_p_q;
	rvb_pkg::acc_t feed_q;
	logic [4:0]  lin_q;
	logic [AW-1:0] clr_q;
	logic signed [41:0] pa_q, pf_q;
	logic signed [39:0] pb_q;
	rvb_pkg::acc_t buf_q, lp_q, xl_q, xr_q;
	logic signed [26:0] accl_q, accr_q;
	logic signed [41:0] ma_q, mb_q;
	logic signed [32:0] mc_q;
	rvb_pkg::sample_t yl_q;
	logic        out_valid_q;
	rvb_pkg::sample_t out_l_q, out_r_q;

	// line state
	logic [PW-1:0] pos_q [rvb_pkg::NUM_LINES];
	rvb_pkg::acc_t lp_mem_q [rvb_pkg::NUM_COMBS];

	// delay memory
	logic [23:0]   dmem [DEPTH];
	logic [23:0]   rd_data;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [23:0]   mem_wdata;

	// derived coefficients
	logic [16:0] fb;
	logic [14:0] damp;
	logic [15:0] wet1, wet2;
	logic [16:0] inv_damp;
	assign fb       = 17'(rvb_pkg::FB_OFFSET) + 17'(room_p_q[30:16]);
	assign damp     = damp_p_q[30:16];
	assign wet1     = w1_p_q[31:16];
	assign wet2     = w2_p_q[31:16];
	assign inv_damp = 17'(rvb_pkg::UNITY - 32'(damp));

	// address of the current line entry
	logic [AW-1:0] line_addr;
	logic [PW-1:0] pos_cur, pos_nxt;
	assign pos_cur   = pos_q[lin_q];
	assign line_addr = AW'(OFF_TAB[lin_q]) + AW'(pos_cur);
	assign pos_nxt   = (pos_cur == PW'(LEN_TAB[lin_q] - 1)) ? '0 : pos_cur + 1'b1;

	// datapath arithmetic
	logic signed [47:0] lp_sum, cw_sum, ap_new, ap_x, mix_l, mix_r;
	rvb_pkg::acc_t ap_in;
	rvb_pkg::acc_t rd_s;
	logic signed [16:0] in_sum;
	logic signed [31:0] feed_p;
	always_comb begin
		rd_s   = rd_data;
		ap_in  = (lin_q < 5'd20) ? xl_q : xr_q;
		lp_sum = (pa_q + pb_q) >>> 16;
		cw_sum = feed_q + (pf_q >>> 16);
		ap_new = ap_in + (rd_s >>> 1);
		ap_x   = rd_s - ap_in;
		if (mode_q) begin
			mix_l = (ma_q + mb_q + (mc_q <<< 3)) >>> 19;
		end else begin
			mix_l = (ma_q + (mc_q <<< 4)) >>> 20;
		end
		mix_r  = (ma_q + mb_q + (mc_q <<< 3)) >>> 19;
		in_sum = in_l_q + in_r_q;
		feed_p = in_sum * $signed({1'b0, 14'(rvb_pkg::FEED_GAIN)});
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = line_addr;
		mem_wdata = '0;
		case (state_q)
			ST_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_CW: begin
				mem_we    = 1'b1;
				mem_wdata = rvb_pkg::sat24(cw_sum);
			end
			ST_AW: begin
				mem_we    = 1'b1;
				mem_wdata = rvb_pkg::sat24(ap_new);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// delay memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[mem_addr] <= mem_wdata;
		end
		rd_data <= dmem[mem_addr];
	end

	// handshakes
	assign in_ch.ready      = (state_q == ST_IDLE);
	assign cfg.ready        = 1'b1;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.left_out  = out_l_q;
	assign out_ch.right_out = out_r_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q    <= 16'd32768;
			damping_q <= 16'd32768;
			wet_q     <= 16'd21845;
			dry_q     <= 16'd0;
			width_q   <= 16'd65535;
			mode_q    <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.idx)
				rvb_pkg::REG_ROOM_SIZE:    room_q    <= cfg.data;
				rvb_pkg::REG_DAMPING:      damping_q <= cfg.data;
				rvb_pkg::REG_WET_LEVEL:    wet_q     <= cfg.data;
				rvb_pkg::REG_DRY_LEVEL:    dry_q     <= cfg.data;
				rvb_pkg::REG_STEREO_WIDTH: width_q   <= cfg.data;
				rvb_pkg::REG_STEREO_MODE:  mode_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// sequencer, line state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			lin_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < rvb_pkg::NUM_LINES; i++) pos_q[i] <= '0;
			for (int i = 0; i < rvb_pkg::NUM_COMBS; i++) lp_mem_q[i] <= '0;
		end else begin
			// output transfer empties the register unless it is reloaded below
			if (out_valid_q && out_ch.ready && state_q != ST_MXF) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_ch.valid) begin
						in_l_q  <= in_ch.left_in;
						in_r_q  <= mode_q ? in_ch.right_in : in_ch.left_in;
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					room_p_q <= room_q * 15'(rvb_pkg::FB_SPAN);
					damp_p_q <= damping_q * 15'(rvb_pkg::DAMP_SCALE);
					w1_p_q   <= wet_q * 17'(32'(width_q >> 1) + rvb_pkg::HALF);
					w2_p_q   <= wet_q * 17'((rvb_pkg::UNITY - 32'(width_q)) >> 1);
					feed_q   <= 24'(feed_p >>> 16);
					accl_q   <= '0;
					accr_q   <= '0;
					lin_q    <= '0;
					state_q  <= ST_RD;
				end
				ST_RD: begin
					state_q <= (lin_q >= 5'd16) ? ST_AW : ST_CM1;
				end
				// comb: lowpass products
				ST_CM1: begin
					buf_q   <= rd_s;
					pa_q    <= rd_s * $signed({1'b0, inv_damp});
					pb_q    <= lp_mem_q[lin_q[3:0]] * $signed({1'b0, damp});
					state_q <= ST_CM2;
				end
				ST_CM2: begin
					lp_q                  <= rvb_pkg::sat24(lp_sum);
					lp_mem_q[lin_q[3:0]]  <= rvb_pkg::sat24(lp_sum);
					state_q               <= ST_CM3;
				end
				ST_CM3: begin
					pf_q    <= lp_q * $signed({1'b0, fb});
					state_q <= ST_CW;
				end
				// comb: write back and accumulate
				ST_CW: begin
					pos_q[lin_q] <= pos_nxt;
					if (lin_q < 5'd8) accl_q <= accl_q + buf_q;
					else              accr_q <= accr_q + buf_q;
					if (lin_q == 5'd15) begin
						state_q <= ST_SUM;
					end else begin
						lin_q   <= lin_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SUM: begin
					xl_q    <= rvb_pkg::sat24(48'(accl_q));
					xr_q    <= rvb_pkg::sat24(48'(accr_q));
					lin_q   <= lin_q + 1'b1;
					state_q <= ST_RD;
				end
				// allpass: write back and pass on
				ST_AW: begin
					pos_q[lin_q] <= pos_nxt;
					if (lin_q < 5'd20) xl_q <= rvb_pkg::sat24(ap_x);
					else               xr_q <= rvb_pkg::sat24(ap_x);
					if (lin_q == 5'd23) begin
						state_q <= ST_MXL;
					end else begin
						lin_q   <= lin_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				// output mix, left products
				ST_MXL: begin
					if (mode_q) begin
						ma_q <= xl_q * $signed({1'b0, wet1});
						mb_q <= xr_q * $signed({1'b0, wet2});
					end else begin
						ma_q <= (25'(xl_q) + 25'(xr_q)) * $signed({1'b0, wet_q});
						mb_q <= '0;
					end
					mc_q    <= in_l_q * $signed({1'b0, dry_q});
					state_q <= ST_MXR;
				end
				// left result, right products
				ST_MXR: begin
					yl_q    <= rvb_pkg::sat16(mix_l);
					ma_q    <= xr_q * $signed({1'b0, wet1});
					mb_q    <= xl_q * $signed({1'b0, wet2});
					mc_q    <= in_r_q * $signed({1'b0, dry_q});
					state_q <= ST_MXF;
				end
				// load output register once it is free
				ST_MXF: begin
					if (!out_valid_q || out_ch.ready) begin
						out_l_q     <= yl_q;
						out_r_q     <= mode_q ? rvb_pkg::sat16(mix_r) : yl_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### tb/sv/tb_rvb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rvb_if
// Channel interfaces as seen by the reverb testbench: the design's own
// interfaces are reused, so this file only gathers the line table the
// predictor needs.
// ----------------------------------------------------------------------------
package tb_rvb_pkg;
	import rvb_pkg::*;

	// delay line lengths scaled to the given rate
	function automatic int unsigned tb_line_len(input int unsigned i, input int unsigned rate);
		longint unsigned b, l;
		if (i < 8)       b = COMB_BASE[i];
		else if (i < 16) b = COMB_BASE[i - 8] + RIGHT_SPREAD;
		else if (i < 20) b = AP_BASE[i - 16];
		else             b = AP_BASE[(i - 20) % 4] + RIGHT_SPREAD;
		l = (b * rate) / REF_RATE;
		return (l < 1) ? 1 : int'(l);
	endfunction
endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the stereo reverb core: a directed table then random
// sample pairs under several register settings, each result compared with a
// bit-exact fixed-point model of the comb/allpass network.
// ----------------------------------------------------------------------------
module tb_top;
	import rvb_pkg::*;
	import tb_rvb_pkg::*;

	localparam int unsigned RATE      = 44100;
	localparam int          WDOG_MAX  = 200000;
	localparam int          TAIL_CYC  = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rvb_in_if  in_ch ();
	rvb_out_if out_ch ();
	rvb_cfg_if cfg ();

	stereo_comb_allpass_reverb_core #(.SAMPLE_RATE(RATE)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// model state
	int unsigned room_r, damp_r, wet_r, dry_r, width_r, mode_r;
	longint      delay_mem [];
	int unsigned line_pos [NUM_LINES];
	int unsigned line_len_t [NUM_LINES];
	int unsigned line_off [NUM_LINES];
	longint      comb_lp [NUM_COMBS];

	typedef struct packed {
		sample_t l;
		sample_t r;
	} pair_t;
	pair_t expected_pairs [$];

	int errors = 0;
	int mismatches = 0;
	int pairs_sent = 0;
	int pairs_checked = 0;
	int idle_cycles = 0;
	bit rx_busy_on = 1'b1;

	function automatic longint shr(input longint x, input int n);
		return x >>> n;
	endfunction

	function automatic longint clip(input longint x, input int bits);
		longint hi, lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	function automatic longint line_read(input int n);
		return delay_mem[line_off[n] + line_pos[n]];
	endfunction

	function automatic void line_write(input int n, input longint v);
		delay_mem[line_off[n] + line_pos[n]] = clip(v, 24);
		line_pos[n] = (line_pos[n] + 1 == line_len_t[n]) ? 0 : line_pos[n] + 1;
	endfunction

	// one channel of the comb/allpass network
	function automatic longint reverb_path(input int cb, input int ab, input longint feed,
			input longint fb, input longint dmp);
		longint sum, b, lp;
		sum = 0;
		for (int i = 0; i < 8; i++) begin
			b  = line_read(cb + i);
			lp = clip(shr(b * (65536 - dmp) + comb_lp[cb + i] * dmp, 16), 24);
			comb_lp[cb + i] = lp;
			line_write(cb + i, feed + shr(lp * fb, 16));
			sum += b;
		end
		sum = clip(sum, 24);
		for (int i = 0; i < 4; i++) begin
			b = line_read(ab + i);
			line_write(ab + i, sum + shr(b, 1));
			sum = clip(b - sum, 24);
		end
		return sum;
	endfunction

	function automatic pair_t reverb_predict(input sample_t li, input sample_t ri);
		longint il, ir, fb, dmp, w1, w2, feed, ol, orr;
		pair_t p;
		il   = li;
		ir   = mode_r ? longint'(ri) : il;
		fb   = 45875 + shr(longint'(room_r) * 18350, 16);
		dmp  = shr(longint'(damp_r) * 26214, 16);
		w1   = shr(longint'(wet_r) * ((width_r >> 1) + 32768), 16);
		w2   = shr(longint'(wet_r) * ((65536 - width_r) >> 1), 16);
		feed = shr((il + ir) * 8 * 983, 16);
		ol   = reverb_path(0, 16, feed, fb, dmp);
		orr  = reverb_path(8, 20, feed, fb, dmp);
		if (mode_r) begin
			p.l = 16'(clip(shr(ol * w1 + orr * w2 + il * dry_r * 8, 19), 16));
			p.r = 16'(clip(shr(orr * w1 + ol * w2 + ir * dry_r * 8, 19), 16));
		end else begin
			p.l = 16'(clip(shr((ol + orr) * wet_r + il * dry_r * 16, 20), 16));
			p.r = p.l;
		end
		return p;
	endfunction

	function automatic void model_reset();
		int unsigned off;
		room_r = 32768; damp_r = 32768; wet_r = 21845;
		dry_r = 0; width_r = 65535; mode_r = 1;
		off = 0;
		for (int i = 0; i < NUM_LINES; i++) begin
			line_len_t[i] = tb_line_len(i, RATE);
			line_off[i] = off;
			off += line_len_t[i];
			line_pos[i] = 0;
		end
		delay_mem = new[off + STORE_PAD];
		foreach (delay_mem[k]) delay_mem[k] = 0;
		foreach (comb_lp[k]) comb_lp[k] = 0;
	endfunction

	function automatic void model_config(input logic [2:0] idx, input logic [15:0] v);
		case (idx)
			REG_ROOM_SIZE:    room_r = v;
			REG_DAMPING:      damp_r = v;
			REG_WET_LEVEL:    wet_r = v;
			REG_DRY_LEVEL:    dry_r = v;
			REG_STEREO_WIDTH: width_r = v;
			REG_STEREO_MODE:  mode_r = v[0];
			default: ;
		endcase
	endfunction

	// watchdog on accepted transfers
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_MAX) begin
			$display("timeout: no transfer for %0d cycles", idle_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stalls, compare each transfer with oldest expectation
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pairs.size() == 0) begin
					errors++;
					if (mismatches++ < 10)
						$display("unexpected result %0d/%0d", out_ch.left_out, out_ch.right_out);
				end else begin
					pair_t e;
					e = expected_pairs.pop_front();
					pairs_checked++;
					if (e.l !== out_ch.left_out || e.r !== out_ch.right_out) begin
						errors++;
						if (mismatches++ < 10)
							$display("mismatch at result %0d: exp %0d/%0d got %0d/%0d",
								pairs_checked, e.l, e.r, out_ch.left_out, out_ch.right_out);
					end
				end
				gap = rx_busy_on ? $urandom_range(0, 10) : 0;
				if (gap > 0) begin
					out_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
		end
	end

	// valid stays high after the transfer, the caller drops it when done
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
		cfg.valid <= 1'b1;
		cfg.idx   <= idx;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		model_config(idx, v);
	endtask

	// valid stays high after the transfer, dropped on a gap or a pause
	task automatic send_pair(input sample_t l, input sample_t r, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.left_in  <= l;
		in_ch.right_in <= r;
		do @(posedge clk); while (!in_ch.ready);
		expected_pairs.push_back(reverb_predict(l, r));
		pairs_sent++;
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
	endtask

	// directed rows: extremes, impulses, silence
	typedef struct {
		sample_t l;
		sample_t r;
	} stim_row_t;
	stim_row_t dir_rows [] = '{
		'{16'sd0, 16'sd0}, '{16'sh7fff, 16'sh7fff}, '{16'sh8000, 16'sh8000},
		'{16'sh7fff, 16'sh8000}, '{16'sh8000, 16'sh7fff}, '{16'sd1, -16'sd1},
		'{16'sh5555, 16'shaaaa}, '{16'shaaaa, 16'sh5555}, '{16'sd0, 16'sd0},
		'{16'sh7fff, 16'sd0}, '{16'sd0, 16'sh7fff}, '{16'sd0, 16'sd0}
	};

	// register settings per phase: room, damping, wet, dry, width, mode
	typedef logic [15:0] reg_set_t [6];
	reg_set_t phase_regs [] = '{
		'{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0001},
		'{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'h0000},
		'{16'h8000, 16'h8000, 16'h5555, 16'h0000, 16'hffff, 16'h0001},
		'{16'hffff, 16'h0000, 16'h8000, 16'h4000, 16'h8000, 16'h0001},
		'{16'h1234, 16'hfedc, 16'h0000, 16'hffff, 16'h0001, 16'h0000}
	};

	initial begin
		in_ch.valid = 1'b0; in_ch.left_in = '0; in_ch.right_in = '0;
		cfg.valid = 1'b0; cfg.idx = '0; cfg.data = '0;
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass at reset settings, no idling
		rx_busy_on = 1'b0;
		foreach (dir_rows[k]) send_pair(dir_rows[k].l, dir_rows[k].r, 1'b0);
		drain_results();
		rx_busy_on = 1'b1;

		// unknown index must be ignored
		write_reg(3'd7, 16'hffff);
		write_reg(3'd6, 16'h0000);

		foreach (phase_regs[p]) begin
			for (int i = 0; i < 6; i++) write_reg(i[2:0], phase_regs[p][i]);
			cfg.valid <= 1'b0;
			// random content with occasional full-scale and silent pairs
			for (int n = 0; n < 180; n++) begin
				sample_t l, r;
				case ($urandom_range(0, 5))
					0: begin l = 16'sh7fff; r = 16'sh8000; end
					1: begin l = 16'sd0; r = 16'sd0; end
					default: begin l = 16'($urandom); r = 16'($urandom); end
				endcase
				send_pair(l, r, (n % 60) < 40);
				if (n == 90) begin
					// hold until every result is in
					in_ch.valid <= 1'b0;
					while (expected_pairs.size() != 0) @(posedge clk);
				end
			end
			drain_results();
		end

		$display("covered %0d sample pairs over %0d register settings, %0d results checked",
			pairs_sent, phase_regs.size() + 1, pairs_checked);
		if (errors == 0 && expected_pairs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### stereo_comb_allpass_reverb_core.f
design/rvb_pkg.sv
design/rvb_if.sv
design/stereo_comb_allpass_reverb_core.sv
tb/sv/tb_rvb_if.sv
tb/sv/tb_top.sv
